/* rtl/core/mexp_pkg.sv */
// Package for the modular exponentiation block: word width, register
// indexes, sequencer state types and the request/response words of the
// shared modular multiplier. No dependencies.
package mexp_pkg;

    localparam int WORD_BITS      = 16;
    localparam int CNT_BITS       = $clog2(WORD_BITS);
    localparam int BIT_IDX_BITS   = $clog2(WORD_BITS + 1);
    localparam int REG_INDEX_BITS = 1;

    typedef logic [WORD_BITS-1:0]      word_t;
    typedef logic [WORD_BITS:0]        wide_t;
    typedef logic [REG_INDEX_BITS-1:0] reg_index_t;

    localparam reg_index_t REG_EXPONENT = 1'b0;
    localparam reg_index_t REG_MODULUS  = 1'b1;

    localparam word_t EXPONENT_RESET = '0;
    localparam word_t MODULUS_RESET  = word_t'(3127);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    typedef enum logic {
        MM_IDLE,
        MM_RUN
    } mm_state_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t n;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mm_rsp_t;

endpackage

/* rtl/core/mexp_mulmod.sv */
// Iterative modular multiplier: a * b mod n, one bit of b per cycle,
// MSB first, with interleaved reduction. Requires a < n.
// Depends on mexp_pkg.
module mexp_mulmod (
    input  logic             clk,
    input  logic             rst_n,
    input  mexp_pkg::mm_req_t req,
    output mexp_pkg::mm_rsp_t rsp
);

    mexp_pkg::mm_state_t              state_reg, state_next;
    logic [mexp_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    mexp_pkg::word_t                  a_reg, b_reg, n_reg, r_reg;

    mexp_pkg::wide_t                  dbl, red1, sum, red2, n_wide;
    mexp_pkg::word_t                  addend;

    always_comb
    begin
        n_wide = {1'b0, n_reg};
        dbl    = {r_reg, 1'b0};
        red1   = (dbl >= n_wide) ? dbl - n_wide : dbl;
        addend = b_reg[mexp_pkg::WORD_BITS-1] ? a_reg : '0;
        sum    = red1 + {1'b0, addend};
        red2   = (sum >= n_wide) ? sum - n_wide : sum;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            mexp_pkg::MM_IDLE:
            begin
                if (req.start)
                begin
                    state_next = mexp_pkg::MM_RUN;
                    cnt_next   = '0;
                end
            end
            mexp_pkg::MM_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mexp_pkg::CNT_BITS'(mexp_pkg::WORD_BITS - 1))
                begin
                    state_next = mexp_pkg::MM_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = mexp_pkg::MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mexp_pkg::MM_IDLE && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            n_reg <= req.n;
            r_reg <= '0;
        end
        else if (state_reg == mexp_pkg::MM_RUN)
        begin
            r_reg <= red2[mexp_pkg::WORD_BITS-1:0];
            b_reg <= {b_reg[mexp_pkg::WORD_BITS-2:0], 1'b0};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule

/* rtl/core/modular_exponentiation.sv */
// Top level of the modular exponentiation block: config registers and the
// square-and-multiply sequencer around one shared mexp_mulmod.
// Depends on mexp_pkg and mexp_mulmod.

// One word at a time: start is taken when busy is low, and busy stays high
// until done pulses for one cycle with cipher = message^exponent mod modulus.
// The receiver cannot stall; cipher is valid only in the done cycle. Each
// modular product runs in the shared bit-serial multiplier. After the accept
// the message is first reduced mod modulus; then for each exponent bit, LSB
// first, the bit is checked, the accumulator is multiplied by the base if the
// bit is set and the base is squared; a final bit check leads to done.
// With modulus below 2 the answer is 0 in the cycle after the accept.
// Exponent and modulus may be written only while busy is low.
module modular_exponentiation (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mexp_pkg::word_t              message,
    output logic                         done,
    output mexp_pkg::word_t              cipher,
    input  logic                         cfg_we,
    input  mexp_pkg::reg_index_t         cfg_index,
    input  mexp_pkg::word_t              cfg_data
);

    mexp_pkg::state_t                     state_reg, state_next;
    mexp_pkg::word_t                      exponent_reg, modulus_reg;
    mexp_pkg::word_t                      acc_reg, acc_next;
    mexp_pkg::word_t                      base_reg, base_next;
    logic [mexp_pkg::BIT_IDX_BITS-1:0]    bit_reg, bit_next;
    mexp_pkg::mm_req_t                    mm_req;
    mexp_pkg::mm_rsp_t                    mm_rsp;

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mexp_pkg::EXPONENT_RESET;
            modulus_reg  <= mexp_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        bit_next     = bit_reg;
        mm_req.start = 1'b0;
        mm_req.a     = base_reg;
        mm_req.b     = base_reg;
        mm_req.n     = modulus_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    bit_next = '0;
                    if (modulus_reg < mexp_pkg::word_t'(2))
                    begin
                        acc_next   = '0;
                        state_next = mexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        // base = message mod n, computed as 1 * message
                        acc_next     = mexp_pkg::word_t'(1);
                        mm_req.start = 1'b1;
                        mm_req.a     = mexp_pkg::word_t'(1);
                        mm_req.b     = message;
                        state_next   = mexp_pkg::ST_REDUCE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.result;
                    state_next = mexp_pkg::ST_NEXT;
                end
            end
            mexp_pkg::ST_NEXT:
            begin
                if (bit_reg == mexp_pkg::BIT_IDX_BITS'(mexp_pkg::WORD_BITS))
                begin
                    state_next = mexp_pkg::ST_DONE;
                end
                else if (exponent_reg[bit_reg[mexp_pkg::CNT_BITS-1:0]])
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_reg;
                    state_next   = mexp_pkg::ST_MUL;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    state_next   = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_next     = mm_rsp.result;
                    mm_req.start = 1'b1;
                    state_next   = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_SQR:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.result;
                    bit_next   = bit_reg + 1'b1;
                    state_next = mexp_pkg::ST_NEXT;
                end
            end
            mexp_pkg::ST_DONE:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
    end

    assign busy   = (state_reg != mexp_pkg::ST_IDLE);
    assign done   = (state_reg == mexp_pkg::ST_DONE);
    assign cipher = acc_reg;

`ifndef ASSERT_OFF
    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_cipher_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cipher < modulus_reg) ||
                 (modulus_reg < mexp_pkg::word_t'(2) && cipher == '0))
        else $error("cipher not reduced below modulus");

    a_mm_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == mexp_pkg::ST_REDUCE ||
                         state_reg == mexp_pkg::ST_MUL ||
                         state_reg == mexp_pkg::ST_SQR))
        else $error("multiplier finished with no product pending");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking bench for modular_exponentiation: a directed table, then random phases of
// message words under changing exponent/modulus settings, all checked in order.
// Depends on mexp_pkg and the modular_exponentiation RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PROBES    = 23;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 600;
    localparam int RAND_WORDS  = 1000;

    typedef struct packed {
        mexp_pkg::word_t expo;
        mexp_pkg::word_t modu;
        mexp_pkg::word_t msg;
        logic            fixed;
        mexp_pkg::word_t want;
    } probe_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    mexp_pkg::word_t      message   = '0;
    logic                 cfg_we    = 1'b0;
    mexp_pkg::reg_index_t cfg_index = mexp_pkg::REG_EXPONENT;
    mexp_pkg::word_t      cfg_data  = '0;
    logic                 busy;
    logic                 done;
    mexp_pkg::word_t      cipher;

    mexp_pkg::word_t cipher_q[$];
    mexp_pkg::word_t exp_shadow = mexp_pkg::EXPONENT_RESET;
    mexp_pkg::word_t mod_shadow = mexp_pkg::MODULUS_RESET;
    mexp_pkg::word_t got_want;
    int              errors       = 0;
    int              stall_cycles = 0;

    // expected value typed in where obvious, 0/0 with fixed low means use the predictor
    probe_t probes [N_PROBES] = '{
        '{16'd0,      16'd3127,  16'd5,      1'b1, 16'd1},
        '{16'd0,      16'd3127,  16'd0,      1'b1, 16'd1},
        '{16'd0,      16'd3127,  16'hFFFF,   1'b1, 16'd1},
        '{16'd1,      16'd3127,  16'd3126,   1'b1, 16'd3126},
        '{16'd1,      16'd3127,  16'd3127,   1'b1, 16'd0},
        '{16'd1,      16'd3127,  16'hFFFF,   1'b0, 16'd0},
        '{16'd1,      16'hFFFF,  16'hFFFF,   1'b1, 16'd0},
        '{16'd1,      16'hFFFF,  16'hFFFE,   1'b1, 16'hFFFE},
        '{16'd2,      16'hFFFF,  16'hFFFE,   1'b1, 16'd1},
        '{16'hFFFF,   16'hFFFF,  16'd0,      1'b1, 16'd0},
        '{16'hFFFF,   16'hFFFF,  16'd1,      1'b1, 16'd1},
        '{16'hFFFF,   16'hFFFF,  16'd2,      1'b0, 16'd0},
        '{16'hFFFF,   16'd2,     16'hFFFF,   1'b1, 16'd1},
        '{16'hFFFF,   16'd2,     16'hFFFE,   1'b1, 16'd0},
        '{16'd5,      16'd0,     16'd1234,   1'b1, 16'd0},
        '{16'd0,      16'd0,     16'd0,      1'b1, 16'd0},
        '{16'd0,      16'd1,     16'hFFFF,   1'b1, 16'd0},
        '{16'hFFFF,   16'd1,     16'd7,      1'b1, 16'd0},
        '{16'd0,      16'd2,     16'd0,      1'b1, 16'd1},
        '{16'h8000,   16'd65521, 16'd3,      1'b0, 16'd0},
        '{16'hAAAA,   16'd3127,  16'h5555,   1'b0, 16'd0},
        '{16'h5555,   16'hFFFE,  16'hAAAA,   1'b0, 16'd0},
        '{16'd3,      16'd3127,  16'd1234,   1'b0, 16'd0}
    };

    modular_exponentiation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .message   (message),
        .done      (done),
        .cipher    (cipher),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic mexp_pkg::word_t power_mod(input mexp_pkg::word_t m,
                                                  input mexp_pkg::word_t e,
                                                  input mexp_pkg::word_t n);
        logic [31:0] acc;
        logic [31:0] sq;
        if (n < 2)
            return '0;
        acc = 1;
        sq  = m % n;
        for (int i = 0; i < mexp_pkg::WORD_BITS; i++)
        begin
            if (e[i])
                acc = (acc * sq) % n;
            sq = (sq * sq) % n;
        end
        return acc[mexp_pkg::WORD_BITS-1:0];
    endfunction

    // returns at a falling edge once nothing is pending and the block is idle
    task automatic drain();
        do
            @(negedge clk);
        while (cipher_q.size() != 0 || busy);
    endtask

    task automatic write_regs(input mexp_pkg::word_t e, input mexp_pkg::word_t n);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= mexp_pkg::REG_EXPONENT;
        cfg_data  <= e;
        @(posedge clk);
        cfg_index <= mexp_pkg::REG_MODULUS;
        cfg_data  <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        exp_shadow = e;
        mod_shadow = n;
    endtask

    task automatic send_word(input mexp_pkg::word_t msg, input logic fixed,
                             input mexp_pkg::word_t want);
        @(posedge clk);
        start   <= 1'b1;
        message <= msg;
        do
            @(posedge clk);
        while (!(start && !busy));
        cipher_q.push_back(fixed ? want : power_mod(msg, exp_shadow, mod_shadow));
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: unexpected cipher word, actual %0d", $time, cipher);
                    errors++;
                end
                else
                begin
                    got_want = cipher_q.pop_front();
                    if (cipher !== got_want)
                    begin
                        $display("%0t: cipher mismatch, expected %0d actual %0d",
                                 $time, got_want, cipher);
                        errors++;
                    end
                end
            end
            if (done || (start && !busy))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: watchdog expired, %0d words pending", $time, cipher_q.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int              sent;
        int              phase_left;
        int              burst_left;
        mexp_pkg::word_t e;
        mexp_pkg::word_t n;
        mexp_pkg::word_t m;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_PROBES; i++)
        begin
            if (probes[i].expo != exp_shadow || probes[i].modu != mod_shadow)
                write_regs(probes[i].expo, probes[i].modu);
            send_word(probes[i].msg, probes[i].fixed, probes[i].want);
        end

        sent       = 0;
        phase_left = 0;
        burst_left = 0;
        while (sent < RAND_WORDS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       e = '0;
                    1:       e = 16'd1;
                    2:       e = 16'hFFFF;
                    3:       e = ($urandom_range(0, 1) != 0) ? 16'd3 : 16'd17;
                    default: e = mexp_pkg::word_t'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0:       n = 16'd2;
                    1:       n = 16'hFFFF;
                    2:       n = mexp_pkg::word_t'($urandom_range(0, 1));
                    3:       n = 16'd3;
                    4:       n = 16'd3127;
                    default: n = mexp_pkg::word_t'($urandom_range(2, 65535));
                endcase
                write_regs(e, n);
                phase_left = $urandom_range(20, 60);
            end
            case ($urandom_range(0, 9))
                0:       m = '0;
                1:       m = 16'hFFFF;
                2:       m = mod_shadow - 16'd1;
                3:       m = mod_shadow;
                default: m = mexp_pkg::word_t'($urandom);
            endcase
            send_word(m, 1'b0, '0);
            sent++;
            phase_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                // some gaps start only once the block has gone idle
                if ($urandom_range(0, 2) == 0)
                    drain();
                repeat ($urandom_range(0, 40)) @(posedge clk);
            end
            else
                burst_left--;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && cipher_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
